// ===== design/rwcs_pkg.sv =====
// Shared types, codes and helpers of the ray-cast wall column shader.
// Used by every module of the block but rwcs_ram; depends on nothing else.
package rwcs_pkg;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_DRAW = 1'b1;

   localparam logic [1:0] FACE_N = 2'd0;
   localparam logic [1:0] FACE_S = 2'd1;
   localparam logic [1:0] FACE_W = 2'd2;
   localparam logic [1:0] FACE_E = 2'd3;

   localparam logic [1:0] REGION_CEILING = 2'd0;
   localparam logic [1:0] REGION_WALL    = 2'd1;
   localparam logic [1:0] REGION_FLOOR   = 2'd2;

   localparam logic [1:0] CSR_CELL_LEN      = 2'd0;
   localparam logic [1:0] CSR_PROJ_DISTANCE = 2'd1;
   localparam logic [1:0] CSR_CEILING_COLOR = 2'd2;
   localparam logic [1:0] CSR_FLOOR_COLOR   = 2'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = 3;

   typedef struct packed {
      logic        cmd;
      logic [1:0]  tex_sel;
      logic [11:0] texel_index;
      logic [31:0] texel_value;
      logic [23:0] ray_distance;
      logic [15:0] cos_angle;
      logic        vertical_first;
      logic [2:0]  quadrant;
      logic [23:0] hit_x;
      logic [23:0] hit_y;
      logic [8:0]  row;
      logic [11:0] column;
   } req_type;

   typedef struct packed {
      logic [11:0] out_column;
      logic [8:0]  out_row;
      logic [31:0] color;
      logic [1:0]  region;
   } rsp_type;

   typedef struct packed {
      logic [12:0] cell_len;
      logic [15:0] projection_distance;
      logic [31:0] ceiling_color;
      logic [31:0] floor_color;
   } cfg_type;

   // One classified request as it waits between front and back.
   typedef struct packed {
      logic        cmd;
      logic [1:0]  face;
      logic [11:0] texel_index;
      logic [31:0] texel_value;
      logic [8:0]  row;
      logic [11:0] column;
      logic [51:0] num;
      logic [39:0] den;
      logic [23:0] coord;
      logic [20:0] span;
   } wk_type;

   function automatic logic [31:0] abgr_to_rgba(input logic [31:0] v);
      abgr_to_rgba = {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

// ===== design/rwcs_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Stands alone; holds the wall textures of the shader.
module rwcs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/rwcs_front.sv =====
// Front end of the shader: takes requests, picks the face and forms the
// division operands. Depends on rwcs_pkg.
module rwcs_front (
   input  logic               clock,
   input  logic               reset,
   input  rwcs_pkg::cfg_type  cfg,
   input  logic               req_valid,
   output logic               req_ready,
   input  rwcs_pkg::req_type  req_data,
   output logic               wk_valid,
   input  logic               wk_ready,
   output rwcs_pkg::wk_type   wk_data
);

   rwcs_pkg::req_type fr_ff;
   logic              fr_vld_ff;
   logic              fr_vld_in;
   logic [1:0]        face;
   logic [28:0]       cell_proj;

   assign req_ready = !fr_vld_ff || wk_ready;

   always_comb begin
      fr_vld_in = fr_vld_ff;
      if (req_valid && req_ready) begin
         fr_vld_in = 1'b1;
      end else if (wk_ready) begin
         fr_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_vld_ff <= 1'b0;
      end else begin
         fr_vld_ff <= fr_vld_in;
      end
      if (req_valid && req_ready) begin
         fr_ff <= req_data;
      end
   end

   // Loads address the texture named in the request; draws use the face hit.
   always_comb begin
      if (fr_ff.cmd == rwcs_pkg::CMD_LOAD) begin
         face = fr_ff.tex_sel;
      end else if (fr_ff.vertical_first) begin
         face = (fr_ff.quadrant == 3'd1 || fr_ff.quadrant == 3'd4) ?
                rwcs_pkg::FACE_W : rwcs_pkg::FACE_E;
      end else begin
         face = (fr_ff.quadrant == 3'd1 || fr_ff.quadrant == 3'd2) ?
                rwcs_pkg::FACE_S : rwcs_pkg::FACE_N;
      end
   end

   assign cell_proj = 29'(cfg.cell_len) * 29'(cfg.projection_distance);

   always_comb begin
      wk_data.cmd         = fr_ff.cmd;
      wk_data.face        = face;
      wk_data.texel_index = fr_ff.texel_index;
      wk_data.texel_value = fr_ff.texel_value;
      wk_data.row         = fr_ff.row;
      wk_data.column      = fr_ff.column;
      wk_data.num         = {cell_proj, 23'd0};
      wk_data.den         = 40'(fr_ff.ray_distance) * 40'(fr_ff.cos_angle);
      wk_data.coord       = (face == rwcs_pkg::FACE_W || face == rwcs_pkg::FACE_E) ?
                            fr_ff.hit_y : fr_ff.hit_x;
      wk_data.span        = {cfg.cell_len, 8'd0};
   end

   assign wk_valid = fr_vld_ff;

endmodule

// ===== design/rwcs_queue.sv =====
// Short request queue between the front and back of the shader.
// Depends on rwcs_pkg.
module rwcs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rwcs_pkg::wk_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output rwcs_pkg::wk_type  out_data
);

   rwcs_pkg::wk_type                        slot_ff [rwcs_pkg::QUEUE_DEPTH];
   logic [rwcs_pkg::QUEUE_PTR_BITS-1:0]     head_ff, tail_ff;
   logic [rwcs_pkg::QUEUE_CNT_BITS-1:0]     count_ff;
   logic                                    push, pop;

   assign in_ready  = count_ff != rwcs_pkg::QUEUE_CNT_BITS'(rwcs_pkg::QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = slot_ff[head_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            tail_ff <= tail_ff + 1'b1;
         end
         if (pop) begin
            head_ff <= head_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (push) begin
         slot_ff[tail_ff] <= in_data;
      end
   end

endmodule

// ===== design/rwcs_back.sv =====
// Back end of the shader: pipelined wall-height and texture-coordinate
// dividers, row classification, texture RAM access and the output register.
// Depends on rwcs_pkg and rwcs_ram.
module rwcs_back #(
   parameter int SCREEN_ROWS = 512,
   parameter int TEX_WIDTH = 64,
   parameter int TEX_HEIGHT = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  rwcs_pkg::cfg_type  cfg,
   input  logic               wk_valid,
   output logic               wk_ready,
   input  rwcs_pkg::wk_type   wk_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rwcs_pkg::rsp_type  rsp_data
);

   localparam int LW = $clog2(TEX_WIDTH);
   localparam int LH = $clog2(TEX_HEIGHT);
   localparam int NB = (LW > LH) ? LW : LH;
   localparam int NA = 17;
   localparam int TEX_WORDS = TEX_WIDTH * TEX_HEIGHT;
   localparam int RAM_DEPTH = 4 * TEX_WORDS;
   localparam int AW = $clog2(RAM_DEPTH);
   localparam logic [17:0] SR18 = 18'(SCREEN_ROWS);

   typedef struct packed {
      logic        vld;
      logic        cmd;
      logic [1:0]  face;
      logic [11:0] tidx;
      logic [31:0] tval;
      logic [8:0]  row;
      logic [11:0] col;
      logic [55:0] hrem;
      logic [39:0] den;
      logic        hsat;
      logic [15:0] hq;
      logic [23:0] mrem;
      logic [20:0] span;
   } sa_type;

   typedef struct packed {
      logic        vld;
      logic        cmd;
      logic [1:0]  face;
      logic [11:0] tidx;
      logic [31:0] tval;
      logic [8:0]  row;
      logic [11:0] col;
      logic [1:0]  region;
      logic [31:0] xrem;
      logic [20:0] span;
      logic        spz;
      logic [9:0]  txq;
      logic [27:0] yrem;
      logic [16:0] yd;
      logic        ysat;
      logic [9:0]  tyq;
   } sb_type;

   typedef struct packed {
      logic        vld;
      logic [8:0]  row;
      logic [11:0] col;
      logic [1:0]  region;
   } sc_type;

   logic              en;
   sa_type            sa_cur [NA];
   sa_type            sa_in  [NA];
   sa_type            sa_ff  [1:NA];
   sb_type            sb_ent;
   sb_type            sb_in  [NB];
   sb_type            sb_ff  [0:NB];
   sc_type            sc_ff;
   rwcs_pkg::rsp_type sd_ff;
   logic              sd_vld_ff;

   logic [15:0]       h0;
   logic [17:0]       h18, ce, flr, fl, r18, t18;
   logic [LW-1:0]     tx_raw, tx;
   logic [LH-1:0]     ty;
   logic [AW-1:0]     rd_addr, wr_addr;
   logic              ram_we;
   logic [31:0]       ram_q;
   logic [31:0]       color;

   // The whole back end advances together unless the output is stalled.
   assign en       = !sd_vld_ff || rsp_ready;
   assign wk_ready = en;

   always_comb begin
      sa_cur[0].vld  = wk_valid;
      sa_cur[0].cmd  = wk_data.cmd;
      sa_cur[0].face = wk_data.face;
      sa_cur[0].tidx = wk_data.texel_index;
      sa_cur[0].tval = wk_data.texel_value;
      sa_cur[0].row  = wk_data.row;
      sa_cur[0].col  = wk_data.column;
      sa_cur[0].hrem = {4'd0, wk_data.num};
      sa_cur[0].den  = wk_data.den;
      sa_cur[0].hsat = 1'b0;
      sa_cur[0].hq   = '0;
      sa_cur[0].mrem = wk_data.coord;
      sa_cur[0].span = wk_data.span;
   end

   // Wall height: an overflow test first, then one quotient bit per stage.
   // The cell remainder of the hit coordinate is reduced alongside.
   for (genvar k = 0; k < NA; k++) begin : g_sa
      if (k > 0) begin : g_cur
         assign sa_cur[k] = sa_ff[k];
      end
      if (k == 0) begin : g_first
         always_comb begin
            sa_in[k] = sa_cur[k];
            if (sa_cur[k].hrem >= {sa_cur[k].den, 16'd0}) begin
               sa_in[k].hsat = 1'b1;
            end
            if (40'(sa_cur[k].mrem) >= (40'(sa_cur[k].span) << 15)) begin
               sa_in[k].mrem = 24'(40'(sa_cur[k].mrem) - (40'(sa_cur[k].span) << 15));
            end
         end
      end else if (k < NA - 1) begin : g_mid
         always_comb begin
            sa_in[k] = sa_cur[k];
            if (!sa_cur[k].hsat &&
                sa_cur[k].hrem >= (56'(sa_cur[k].den) << (NA - 1 - k))) begin
               sa_in[k].hrem = sa_cur[k].hrem - (56'(sa_cur[k].den) << (NA - 1 - k));
               sa_in[k].hq[NA-1-k] = 1'b1;
            end
            if (40'(sa_cur[k].mrem) >= (40'(sa_cur[k].span) << (15 - k))) begin
               sa_in[k].mrem = 24'(40'(sa_cur[k].mrem) -
                                   (40'(sa_cur[k].span) << (15 - k)));
            end
         end
      end else begin : g_last
         always_comb begin
            sa_in[k] = sa_cur[k];
            if (!sa_cur[k].hsat && sa_cur[k].hrem >= 56'(sa_cur[k].den)) begin
               sa_in[k].hrem = sa_cur[k].hrem - 56'(sa_cur[k].den);
               sa_in[k].hq[0] = 1'b1;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sa_ff[k+1].vld <= 1'b0;
         end else if (en) begin
            sa_ff[k+1] <= sa_in[k];
         end
      end
   end

   // Column bounds, region and the operands of the texture dividers.
   always_comb begin
      h0  = sa_ff[NA].hsat ? 16'hFFFF : sa_ff[NA].hq;
      h18 = 18'(h0);
      r18 = 18'(sa_ff[NA].row);
      ce  = (h18 < SR18) ? ((SR18 - h18) >> 1) : '0;
      flr = (SR18 + h18) >> 1;
      fl  = (flr > SR18 - 18'd1) ? SR18 - 18'd1 : flr;
      t18 = h18 + (r18 << 1);
      t18 = (t18 > SR18) ? t18 - SR18 : '0;

      sb_ent.vld  = sa_ff[NA].vld;
      sb_ent.cmd  = sa_ff[NA].cmd;
      sb_ent.face = sa_ff[NA].face;
      sb_ent.tidx = sa_ff[NA].tidx;
      sb_ent.tval = sa_ff[NA].tval;
      sb_ent.row  = sa_ff[NA].row;
      sb_ent.col  = sa_ff[NA].col;
      if (r18 < ce) begin
         sb_ent.region = rwcs_pkg::REGION_CEILING;
      end else if (r18 <= fl && h0 != 16'd0) begin
         sb_ent.region = rwcs_pkg::REGION_WALL;
      end else begin
         sb_ent.region = rwcs_pkg::REGION_FLOOR;
      end
      sb_ent.xrem = 32'(sa_ff[NA].mrem) * 32'(TEX_WIDTH);
      sb_ent.span = sa_ff[NA].span;
      sb_ent.spz  = sa_ff[NA].span == '0;
      sb_ent.txq  = '0;
      sb_ent.yrem = 28'(t18) * 28'(TEX_HEIGHT);
      sb_ent.yd   = {h0, 1'b0};
      sb_ent.ysat = t18 >= 18'({h0, 1'b0});
      sb_ent.tyq  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_ff[0].vld <= 1'b0;
      end else if (en) begin
         sb_ff[0] <= sb_ent;
      end
   end

   // Texture x and y: one quotient bit of each per stage.
   for (genvar k = 0; k < NB; k++) begin : g_sb
      always_comb begin
         sb_in[k] = sb_ff[k];
         if (sb_ff[k].xrem >= (32'(sb_ff[k].span) << (NB - 1 - k))) begin
            sb_in[k].xrem = sb_ff[k].xrem - (32'(sb_ff[k].span) << (NB - 1 - k));
            sb_in[k].txq[NB-1-k] = 1'b1;
         end
         if (sb_ff[k].yrem >= (28'(sb_ff[k].yd) << (NB - 1 - k))) begin
            sb_in[k].yrem = sb_ff[k].yrem - (28'(sb_ff[k].yd) << (NB - 1 - k));
            sb_in[k].tyq[NB-1-k] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sb_ff[k+1].vld <= 1'b0;
         end else if (en) begin
            sb_ff[k+1] <= sb_in[k];
         end
      end
   end

   // Texel address; east and north faces are mirrored in x.
   always_comb begin
      tx_raw = sb_ff[NB].spz ? '0 : sb_ff[NB].txq[LW-1:0];
      tx = (sb_ff[NB].face == rwcs_pkg::FACE_E || sb_ff[NB].face == rwcs_pkg::FACE_N) ?
           LW'(TEX_WIDTH - 1) - tx_raw : tx_raw;
      ty = sb_ff[NB].ysat ? LH'(TEX_HEIGHT - 1) : sb_ff[NB].tyq[LH-1:0];
      rd_addr = AW'(sb_ff[NB].face) * AW'(TEX_WORDS) + AW'(ty) * AW'(TEX_WIDTH) + AW'(tx);
      wr_addr = AW'(sb_ff[NB].face) * AW'(TEX_WORDS) + AW'(sb_ff[NB].tidx);
      ram_we  = en && sb_ff[NB].vld && sb_ff[NB].cmd == rwcs_pkg::CMD_LOAD &&
                32'(sb_ff[NB].tidx) < 32'(TEX_WORDS);
   end

   rwcs_ram #(
      .WIDTH     (32),
      .DEPTH     (RAM_DEPTH),
      .ADDR_BITS (AW)
   ) u_tex_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr),
      .wr_data (sb_ff[NB].tval),
      .rd_en   (en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff.vld <= 1'b0;
      end else if (en) begin
         sc_ff.vld    <= sb_ff[NB].vld && sb_ff[NB].cmd == rwcs_pkg::CMD_DRAW;
         sc_ff.row    <= sb_ff[NB].row;
         sc_ff.col    <= sb_ff[NB].col;
         sc_ff.region <= sb_ff[NB].region;
      end
   end

   always_comb begin
      case (sc_ff.region)
         rwcs_pkg::REGION_CEILING: color = cfg.ceiling_color;
         rwcs_pkg::REGION_WALL:    color = rwcs_pkg::abgr_to_rgba(ram_q);
         default:                  color = cfg.floor_color;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sd_vld_ff <= 1'b0;
      end else if (en) begin
         sd_vld_ff <= sc_ff.vld;
      end
      if (en) begin
         sd_ff.out_column <= sc_ff.col;
         sd_ff.out_row    <= sc_ff.row;
         sd_ff.color      <= color;
         sd_ff.region     <= sc_ff.region;
      end
   end

   assign rsp_valid = sd_vld_ff;
   assign rsp_data  = sd_ff;

   a_we_only_load: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> sb_ff[NB].cmd == rwcs_pkg::CMD_LOAD)
      else $error("texture write issued for a draw request");

   a_wall_nonzero: assert property (@(posedge clock) disable iff (reset)
      sb_ff[0].vld && sb_ff[0].region == rwcs_pkg::REGION_WALL |-> sb_ff[0].yd != '0)
      else $error("wall pixel with zero wall height");

   a_sat_clean: assert property (@(posedge clock) disable iff (reset)
      sa_ff[NA].vld && sa_ff[NA].hsat |-> sa_ff[NA].hq == '0)
      else $error("saturated wall height carries quotient bits");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(sd_ff) && $stable(sc_ff))
      else $error("back end moved while the output was stalled");

endmodule

// ===== design/raycast_wall_column_shader.sv =====
// Ray-cast wall column shader, top level.
// Channels: req_* carries load-texel and shade-pixel requests (valid/ready);
// rsp_* returns one shaded pixel per shade request, none per load; csr_*
// writes cell length, projection distance, ceiling color and floor color,
// index 0 to 3, with no wait and no read-back.
// Throughput: one request per clock while rsp_ready is high, loads and shades mixed.
// Path: the front register and the queue, then the back-end pipeline:
// seventeen wall-height divider stages, a register for the region and
// texture-divider operands, one stage per texture coordinate bit, then
// the texture RAM read and the output register.
// Loads write the texture RAM in request order, so a shade that follows a
// load sees the new texel.
// Reset: configuration returns to cell 64, projection 277, colors 0; the
// pipeline and queue empty. Texture contents are undefined until loaded.
// Stall: while a result waits with rsp_ready low the back end holds; the
// four-entry queue and front register keep accepting requests until they fill.
// Depends on rwcs_pkg, rwcs_front, rwcs_queue, rwcs_back and rwcs_ram.
module raycast_wall_column_shader #(
   parameter int SCREEN_ROWS = 512,
   parameter int TEX_WIDTH = 64,
   parameter int TEX_HEIGHT = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rwcs_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rwcs_pkg::rsp_type  rsp_data,
   input  logic               csr_we,
   input  logic [1:0]         csr_addr,
   input  logic [31:0]        csr_wdata
);

   rwcs_pkg::cfg_type cfg_ff;
   logic              fq_valid, fq_ready, qb_valid, qb_ready;
   rwcs_pkg::wk_type  fq_data, qb_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cell_len            <= 13'd64;
         cfg_ff.projection_distance <= 16'd277;
         cfg_ff.ceiling_color       <= '0;
         cfg_ff.floor_color         <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            rwcs_pkg::CSR_CELL_LEN:      cfg_ff.cell_len <= csr_wdata[12:0];
            rwcs_pkg::CSR_PROJ_DISTANCE: cfg_ff.projection_distance <= csr_wdata[15:0];
            rwcs_pkg::CSR_CEILING_COLOR: cfg_ff.ceiling_color <= csr_wdata;
            rwcs_pkg::CSR_FLOOR_COLOR:   cfg_ff.floor_color <= csr_wdata;
            default: ;
         endcase
      end
   end

   rwcs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .wk_valid  (fq_valid),
      .wk_ready  (fq_ready),
      .wk_data   (fq_data)
   );

   rwcs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   rwcs_back #(
      .SCREEN_ROWS (SCREEN_ROWS),
      .TEX_WIDTH   (TEX_WIDTH),
      .TEX_HEIGHT  (TEX_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .wk_valid  (qb_valid),
      .wk_ready  (qb_ready),
      .wk_data   (qb_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
